[sv/psib_pkg.sv]
// shared types and constants of the priority sorted insert buffer
`default_nettype none

package psib_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 8;
  localparam int BUS_DATA_W = 64;
  localparam int TDATA_W    = KEY_W + BUS_DATA_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_ENTRY  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;
    logic reject;
    logic empty;
    logic pop;
  } psib_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic full;
    logic out_valid;
  } psib_status_t;

endpackage

`default_nettype wire

[sv/psib_ctrl.sv]
// controller state machine of the priority sorted insert buffer
`default_nettype none

module psib_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_command,
  input  wire logic                  m_tready,
  input  wire psib_pkg::psib_status_t status,
  output logic                       s_tready,
  output psib_pkg::psib_cmd_t        cmd
);
  import psib_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  // output register can take a new result this cycle
  assign out_free = !status.out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_command == CMD_INSERT) begin
            if (status.full) begin
              cmd.reject = 1'b1;
            end else begin
              cmd.insert = 1'b1;
            end
          end else if (status.count_zero) begin
            cmd.empty = 1'b1;
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          cmd.pop = 1'b1;
          if (status.count_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[sv/psib_dp.sv]
// datapath of the priority sorted insert buffer: sorted cells and result register
`default_nettype none

module psib_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire psib_pkg::psib_cmd_t               cmd,
  input  wire logic signed [psib_pkg::KEY_W-1:0] in_key,
  input  wire logic [psib_pkg::BUS_DATA_W-1:0]   in_data,
  input  wire logic                              m_tready,
  output psib_pkg::psib_status_t                 status,
  output logic                                   m_tvalid,
  output logic [1:0]                             m_kind,
  output logic signed [psib_pkg::KEY_W-1:0]      m_priority,
  output logic [psib_pkg::BUS_DATA_W-1:0]        m_data,
  output logic                                   m_last
);
  import psib_pkg::*;

  logic signed [KEY_W-1:0]  key_cell [CAPACITY];
  logic [DATA_WIDTH-1:0]    data_cell [CAPACITY];
  logic signed [KEY_W-1:0]  key_cell_next [CAPACITY];
  logic [DATA_WIDTH-1:0]    data_cell_next [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CAPACITY-1:0]      gt_below;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [DATA_WIDTH-1:0]    new_data;
  logic [BUS_DATA_W-1:0]    head_data;
  logic                     load;

  assign new_data = in_data[DATA_WIDTH-1:0];

  // per cell compare: stored key is strictly greater than the new key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < count) && (key_cell[i] > in_key);
    end
  end

  assign gt_below = {gt[CAPACITY-2:0], 1'b0};

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [KEY_W-1:0] key_above;
    logic [DATA_WIDTH-1:0]   data_above;
    logic signed [KEY_W-1:0] key_below;
    logic [DATA_WIDTH-1:0]   data_below;

    if (gi == CAPACITY - 1) begin : g_top
      assign key_above  = key_cell[gi];
      assign data_above = data_cell[gi];
    end else begin : g_mid
      assign key_above  = key_cell[gi+1];
      assign data_above = data_cell[gi+1];
    end

    if (gi == 0) begin : g_bot
      assign key_below  = key_cell[gi];
      assign data_below = data_cell[gi];
    end else begin : g_up
      assign key_below  = key_cell[gi-1];
      assign data_below = data_cell[gi-1];
    end

    always_comb begin
      key_cell_next[gi]  = key_cell[gi];
      data_cell_next[gi] = data_cell[gi];
      if (cmd.insert) begin
        if (gt_below[gi]) begin
          key_cell_next[gi]  = key_below;
          data_cell_next[gi] = data_below;
        end else if (gt[gi] || (count == CNT_W'(gi))) begin
          key_cell_next[gi]  = in_key;
          data_cell_next[gi] = new_data;
        end
      end else if (cmd.pop) begin
        key_cell_next[gi]  = key_above;
        data_cell_next[gi] = data_above;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_cell[i]  <= key_cell_next[i];
      data_cell[i] <= data_cell_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == CNT_W'(1));
  assign status.full       = (count == CNT_W'(CAPACITY));
  assign status.out_valid  = m_tvalid;

  always_comb begin
    head_data                   = '0;
    head_data[DATA_WIDTH-1:0]   = data_cell[0];
  end

  assign load = cmd.insert || cmd.reject || cmd.empty || cmd.pop;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= load || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_priority <= '0;
      m_data     <= '0;
      m_last     <= 1'b1;
      if (cmd.pop) begin
        m_kind     <= KIND_ENTRY;
        m_priority <= key_cell[0];
        m_data     <= head_data;
        m_last     <= (count == CNT_W'(1));
      end else if (cmd.reject) begin
        m_kind <= KIND_REJECT;
      end else if (cmd.empty) begin
        m_kind <= KIND_EMPTY;
      end else begin
        m_kind <= KIND_ACCEPT;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    cmd.reject |-> status.full)
    else $error("insert rejected while table has room");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_kind == KIND_ENTRY && m_last) |-> count == '0)
    else $error("final flushed item while entries remain");
`endif

endmodule

`default_nettype wire

[sv/priority_sorted_insert_buffer_unit.sv]
// top level of the priority sorted insert buffer
//
//  channel  dir  tdata                               tuser          tlast
//  s_*      in   [7:0] priority_req, [71:8] entry_data [0] command    -
//  m_*      out  [7:0] out_priority, [71:8] out_data   [1:0] kind     last
//
// an insert or empty flush writes its result into the result register when it is accepted
// a flush streams one stored entry per cycle while the result register is free, count entries in all
// input is taken only when no flush is running and the result register is free
// output stalls hold the result register and block new input items
// rst clears the entry count, controller state and result valid; cells keep stale data
`default_nettype none

module priority_sorted_insert_buffer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [psib_pkg::TDATA_W-1:0]   s_tdata,  // priority_req, entry_data
  input  wire logic [0:0]                     s_tuser,  // command
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [psib_pkg::TDATA_W-1:0]        m_tdata,  // out_priority, out_data
  output logic [1:0]                          m_tuser,  // kind
  output logic                                m_tlast
);
  import psib_pkg::*;

  psib_cmd_t               cmd;
  psib_status_t            status;
  logic signed [KEY_W-1:0] m_priority;
  logic [BUS_DATA_W-1:0]   m_data;

  psib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_command (s_tuser[0]),
    .m_tready  (m_tready),
    .status    (status),
    .s_tready  (s_tready),
    .cmd       (cmd)
  );

  psib_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_key     (s_tdata[KEY_W-1:0]),
    .in_data    (s_tdata[TDATA_W-1:KEY_W]),
    .m_tready   (m_tready),
    .status     (status),
    .m_tvalid   (m_tvalid),
    .m_kind     (m_tuser),
    .m_priority (m_priority),
    .m_data     (m_data),
    .m_last     (m_tlast)
  );

  assign m_tdata = {m_data, m_priority};

endmodule

`default_nettype wire
